### rtl/adaptive_send_spacing_control_assert.svh
// Assertion macros for the send spacing controller.
// Each macro expects clk and rst_n to be visible in the module that uses it.
`ifndef ADAPTIVE_SEND_SPACING_CONTROL_ASSERT_SVH
`define ADAPTIVE_SEND_SPACING_CONTROL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/assc_pkg.sv
// Shared types and constants for the send spacing controller.
// No dependencies.
package assc_pkg;

  localparam int TIME_WIDTH   = 32;
  localparam int ID_WIDTH     = 16;
  localparam int WEIGHT_WIDTH = 16;
  localparam int COUNT_WIDTH  = 32;
  localparam int CFG_DATA_WIDTH  = 32;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int GROW_FRAC_BITS  = 12;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_TIMER = 2'd1,
    CMD_ACK   = 2'd2,
    CMD_OTHER = 2'd3
  } cmd_t;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_START_ID      = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_INIT_SPACING  = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_INCREASE_W    = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SLOW_DECR_W   = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FAST_DECR_W   = 3'd4;

  localparam logic [ID_WIDTH-1:0]     START_ID_RST     = 16'd0;
  localparam logic [TIME_WIDTH-1:0]   INIT_SPACING_RST = 32'd700000;
  localparam logic [WEIGHT_WIDTH-1:0] INCREASE_W_RST   = 16'd6144;
  localparam logic [WEIGHT_WIDTH-1:0] SLOW_DECR_W_RST  = 16'd655;
  localparam logic [WEIGHT_WIDTH-1:0] FAST_DECR_W_RST  = 16'd32768;

endpackage

### rtl/adaptive_send_spacing_control.sv
// Top level of the send spacing controller: input register, pacing update, result register.
// Depends on assc_pkg and adaptive_send_spacing_control_assert.svh.
//
//   channel  | direction | handshake             | payload
//   in_      | input     | in_valid / in_stall   | cmd, ack_id, now_us
//   out_     | output    | out_valid / out_stall | send_valid .. ack_count
//   cfg_     | input     | cfg_we                | cfg_index, cfg_wdata
//
// One beat per cycle without out_stall; each beat moves from the input to the result register.
// The single 32x16 spacing multiply and the compare against the round-trip sample set the path.
// Reset is synchronous, active low, and loads the register defaults and a cleared pacing state.
// in_stall rises only while the input register holds a beat and the result register is stalled.
`include "adaptive_send_spacing_control_assert.svh"

module adaptive_send_spacing_control import assc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_cmd,
  input  logic [ID_WIDTH-1:0]        in_ack_id,
  input  logic [TIME_WIDTH-1:0]      in_now_us,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_send_valid,
  output logic [ID_WIDTH-1:0]        out_packet_id,
  output logic [TIME_WIDTH-1:0]      out_next_send_time,
  output logic [TIME_WIDTH-1:0]      out_spacing_us,
  output logic                       out_id_matched,
  output logic [COUNT_WIDTH-1:0]     out_sent_count,
  output logic [COUNT_WIDTH-1:0]     out_ack_count,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_wdata
);

  localparam int PROD_WIDTH = TIME_WIDTH + WEIGHT_WIDTH;

  logic [ID_WIDTH-1:0]     start_id_r;
  logic [TIME_WIDTH-1:0]   init_spacing_r;
  logic [WEIGHT_WIDTH-1:0] increase_w_r;
  logic [WEIGHT_WIDTH-1:0] slow_decr_w_r;
  logic [WEIGHT_WIDTH-1:0] fast_decr_w_r;

  logic                  in_vld_r;
  cmd_t                  cmd_r;
  logic [ID_WIDTH-1:0]   ack_id_r;
  logic [TIME_WIDTH-1:0] now_r;

  logic [TIME_WIDTH-1:0]  spacing_r, spacing_nxt;
  logic [TIME_WIDTH-1:0]  loss_spacing_r, loss_spacing_nxt;
  logic [TIME_WIDTH-1:0]  rtt_r, rtt_nxt;
  logic [TIME_WIDTH-1:0]  last_send_r, last_send_nxt;
  logic [ID_WIDTH-1:0]    cur_id_r, cur_id_nxt;
  logic                   ack_seen_r, ack_seen_nxt;
  logic [COUNT_WIDTH-1:0] sent_total_r, sent_total_nxt;
  logic [COUNT_WIDTH-1:0] ack_total_r, ack_total_nxt;

  logic                  send;
  logic                  matched;
  logic [TIME_WIDTH-1:0] next_time;

  logic                    out_vld_r;
  logic                    advance;
  logic [WEIGHT_WIDTH-1:0] weight;
  logic [PROD_WIDTH-1:0]   prod;
  logic [TIME_WIDTH-1:0]   grown;
  logic [TIME_WIDTH-1:0]   shrunk;
  logic [TIME_WIDTH-1:0]   adjusted;

  assign advance   = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = in_vld_r && !advance;
  assign out_valid = out_vld_r;

  always_comb begin
    if (!ack_seen_r) begin
      weight = increase_w_r;
    end else if (spacing_r >= loss_spacing_r) begin
      weight = slow_decr_w_r;
    end else begin
      weight = fast_decr_w_r;
    end
    prod = {{WEIGHT_WIDTH{1'b0}}, spacing_r} * {{TIME_WIDTH{1'b0}}, weight};
    if (|prod[PROD_WIDTH-1:TIME_WIDTH+GROW_FRAC_BITS]) begin
      grown = {TIME_WIDTH{1'b1}};
    end else begin
      grown = prod[TIME_WIDTH+GROW_FRAC_BITS-1:GROW_FRAC_BITS];
    end
    shrunk   = spacing_r - prod[PROD_WIDTH-1:WEIGHT_WIDTH];
    adjusted = ack_seen_r ? shrunk : grown;
  end

  always_comb begin
    spacing_nxt      = spacing_r;
    loss_spacing_nxt = loss_spacing_r;
    rtt_nxt          = rtt_r;
    last_send_nxt    = last_send_r;
    cur_id_nxt       = cur_id_r;
    ack_seen_nxt     = ack_seen_r;
    sent_total_nxt   = sent_total_r;
    ack_total_nxt    = ack_total_r;
    send             = 1'b0;
    matched          = 1'b0;
    unique case (cmd_r)
      CMD_START: begin
        cur_id_nxt  = start_id_r;
        spacing_nxt = init_spacing_r;
        send        = 1'b1;
      end
      CMD_TIMER: begin
        if (ack_seen_r) begin
          cur_id_nxt    = cur_id_r + 1'b1;
          ack_total_nxt = ack_total_r + 1'b1;
        end else begin
          loss_spacing_nxt = spacing_r;
        end
        spacing_nxt  = (adjusted < rtt_r) ? rtt_r : adjusted;
        ack_seen_nxt = 1'b0;
        send         = 1'b1;
      end
      CMD_ACK: begin
        if (ack_id_r == cur_id_r) begin
          matched      = 1'b1;
          ack_seen_nxt = 1'b1;
        end
        rtt_nxt = now_r - last_send_r;
      end
      default: begin
      end
    endcase
    next_time = '0;
    if (send) begin
      sent_total_nxt = sent_total_r + 1'b1;
      last_send_nxt  = now_r;
      next_time      = now_r + spacing_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_id_r     <= START_ID_RST;
      init_spacing_r <= INIT_SPACING_RST;
      increase_w_r   <= INCREASE_W_RST;
      slow_decr_w_r  <= SLOW_DECR_W_RST;
      fast_decr_w_r  <= FAST_DECR_W_RST;
      in_vld_r       <= 1'b0;
      out_vld_r      <= 1'b0;
      spacing_r      <= '0;
      loss_spacing_r <= '0;
      rtt_r          <= '0;
      last_send_r    <= '0;
      cur_id_r       <= '0;
      ack_seen_r     <= 1'b0;
      sent_total_r   <= '0;
      ack_total_r    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_START_ID:     start_id_r     <= cfg_wdata[ID_WIDTH-1:0];
          REG_INIT_SPACING: init_spacing_r <= cfg_wdata[TIME_WIDTH-1:0];
          REG_INCREASE_W:   increase_w_r   <= cfg_wdata[WEIGHT_WIDTH-1:0];
          REG_SLOW_DECR_W:  slow_decr_w_r  <= cfg_wdata[WEIGHT_WIDTH-1:0];
          REG_FAST_DECR_W:  fast_decr_w_r  <= cfg_wdata[WEIGHT_WIDTH-1:0];
          default: begin
          end
        endcase
      end
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r      <= 1'b1;
        spacing_r      <= spacing_nxt;
        loss_spacing_r <= loss_spacing_nxt;
        rtt_r          <= rtt_nxt;
        last_send_r    <= last_send_nxt;
        cur_id_r       <= cur_id_nxt;
        ack_seen_r     <= ack_seen_nxt;
        sent_total_r   <= sent_total_nxt;
        ack_total_r    <= ack_total_nxt;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmd_r    <= cmd_t'(in_cmd);
      ack_id_r <= in_ack_id;
      now_r    <= in_now_us;
    end
    if (advance) begin
      out_send_valid     <= send;
      out_packet_id      <= cur_id_nxt;
      out_next_send_time <= next_time;
      out_spacing_us     <= spacing_nxt;
      out_id_matched     <= matched;
      out_sent_count     <= sent_total_nxt;
      out_ack_count      <= ack_total_nxt;
    end
  end

  `ASSC_ASSERT_NEXT(a_timer_floor, advance && (cmd_r == CMD_TIMER),
    out_send_valid && (out_spacing_us >= rtt_r), "timer beat left spacing below rtt")
  `ASSC_ASSERT_SAME(a_idle_time, out_vld_r && !out_send_valid,
    out_next_send_time == '0, "next send time set without a send")
  `ASSC_ASSERT_SAME(a_match_no_send, out_vld_r && out_id_matched,
    !out_send_valid, "id match reported on a sending beat")
  `ASSC_ASSERT_NEXT(a_ack_count, advance && (cmd_r == CMD_TIMER) && ack_seen_r,
    ack_total_r == $past(ack_total_r) + 1'b1, "ack count did not advance")
  `ASSC_ASSERT_SAME(a_hold_input, in_vld_r && out_vld_r && out_stall,
    in_stall, "input taken while result register is stalled")

endmodule
